### sv/tlru_pkg.sv
package tlru_pkg;

   localparam int ENTRIES_DEF  = 128;
   localparam int KEY_BITS_DEF = 64;

   localparam int CFG_BITS   = 16;
   localparam int HANDLE_BITS = 32;
   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 8;

   localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 16'd300;
   localparam logic [CFG_BITS-1:0] MAX_AGE_RESET  = 16'd1800;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_GET   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_TOUCH = 2'd3;

   localparam logic REG_INTERVAL = 1'b0;
   localparam logic REG_MAX_AGE  = 1'b1;

   // request tdata: operation, lookup_key, handle_in, entry_time, current_time
   localparam int REQ_BITS = 2 + 64 + 32 + 32 + 32;
   localparam int REQ_BYTES_BITS = ((REQ_BITS + 7) / 8) * 8;
   // response tdata: hit, handle_out, entry_count
   localparam int RSP_BITS = 1 + 32 + 8;
   localparam int RSP_BYTES_BITS = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [1:0]             op;
      logic [63:0]            key;
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_BITS-1:0]   etime;
      logic [TIME_BITS-1:0]   now;
   } req_type;

   typedef struct packed {
      logic                   hit;
      logic [HANDLE_BITS-1:0] handle;
      logic [COUNT_BITS-1:0]  count;
   } rsp_type;

endpackage

### sv/tlru_store.sv
module tlru_store #(
   parameter int ENTRIES  = tlru_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = tlru_pkg::KEY_BITS_DEF,
   parameter int IDX_BITS = $clog2(ENTRIES),
   parameter int W        = KEY_BITS + tlru_pkg::HANDLE_BITS + tlru_pkg::TIME_BITS
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  logic [W-1:0]        wr_data,
   input  logic [IDX_BITS-1:0] rd_addr,
   output logic [W-1:0]        rd_data
);
   logic [W-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### sv/timestamp_lru_cache_with_ageout.sv
// channel | direction | contents
// req_    | in        | tdata: operation, lookup_key, handle_in, entry_time, current_time
// rsp_    | out       | tdata: hit, handle_out, entry_count
// csr_    | in        | index 0 cleanup_interval, index 1 max_age
// items that scan the table read one entry per cycle through a single read port:
// get/touch scan until the matching entry or the fill count, clear does not scan,
// add runs an age-out pass over the filled entries when the cleanup interval is due
// and, when the table is full, a victim search over all ENTRIES entries
// reset is synchronous; table contents need no clearing, fill count resets to zero
// req_tready is low while an item is in work or its result waits on rsp_tready
module timestamp_lru_cache_with_ageout #(
   parameter int ENTRIES  = tlru_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = tlru_pkg::KEY_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // operation, lookup_key, handle_in, entry_time, current_time
   input  logic [tlru_pkg::REQ_BYTES_BITS-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // hit, handle_out, entry_count
   output logic [tlru_pkg::RSP_BYTES_BITS-1:0]    rsp_tdata,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [tlru_pkg::CFG_BITS-1:0]          csr_wdata
);
   import tlru_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int W = KEY_BITS + HANDLE_BITS + TIME_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_AGE    = 3'd1;
   localparam logic [2:0] ST_APPEND = 3'd2;
   localparam logic [2:0] ST_VICTIM = 3'd3;
   localparam logic [2:0] ST_FIND   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   req_type req_ff, req_in;
   logic [CFG_BITS-1:0] interval_ff, interval_in, max_age_ff, max_age_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [CNT_BITS-1:0] rd_ff, rd_in;   // address issued
   logic [CNT_BITS-1:0] wr_ff, wr_in;   // compaction write pointer
   logic pend_ff, pend_in;              // a read is in flight
   logic [IDX_BITS-1:0] paddr_ff, paddr_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0] best_t_ff, best_t_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic mem_we;
   logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
   logic [W-1:0] mem_wdata, mem_rdata;
   logic [KEY_BITS-1:0] r_key;
   logic [HANDLE_BITS-1:0] r_handle;
   logic [TIME_BITS-1:0] r_time;
   logic [KEY_BITS-1:0] q_key;
   logic [TIME_BITS:0] limit;
   logic [TIME_BITS-1:0] elapsed;
   logic age_due;

   assign {r_key, r_handle, r_time} = mem_rdata;
   assign q_key = req_ff.key[KEY_BITS-1:0];
   assign limit = {1'b0, r_time} + {{(TIME_BITS+1-CFG_BITS){1'b0}}, max_age_ff};
   assign elapsed = req_ff.now - last_ff;
   assign age_due = (req_ff.now >= last_ff) &&
      (elapsed >= {{(TIME_BITS-CFG_BITS){1'b0}}, interval_ff});

   tlru_store #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .IDX_BITS(IDX_BITS), .W(W))
   u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_BYTES_BITS-RSP_BITS){1'b0}}, rsp_ff.count, rsp_ff.handle,
                       rsp_ff.hit};

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      interval_in = interval_ff;
      max_age_in = max_age_ff;
      fill_in = fill_ff;
      last_in = last_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      pend_in = 1'b0;
      paddr_in = paddr_ff;
      best_idx_in = best_idx_ff;
      best_t_in = best_t_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = {r_key, r_handle, r_time};
      mem_raddr = rd_ff[IDX_BITS-1:0];

      if (csr_we) begin
         if (csr_index == REG_INTERVAL) interval_in = csr_wdata;
         else max_age_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               req_in = {req_tdata[1:0], req_tdata[65:2], req_tdata[97:66],
                         req_tdata[129:98], req_tdata[161:130]};
               rd_in = '0;
               wr_in = '0;
               unique case (req_tdata[1:0])
                  OP_ADD:   state_in = ST_AGE;
                  OP_CLEAR: begin
                     fill_in = '0;
                     state_in = ST_DONE;
                  end
                  default:  state_in = ST_FIND;
               endcase
            end
         end
         ST_AGE: begin
            if (!age_due) begin
               state_in = ST_APPEND;
            end else begin
               // read one entry a cycle, keep survivors at the write pointer
               if (pend_ff && r_handle != '0 && limit > {1'b0, req_ff.now}) begin
                  mem_we = 1'b1;
                  mem_waddr = wr_ff[IDX_BITS-1:0];
                  wr_in = wr_ff + 1'b1;
               end
               if (rd_ff < fill_ff) begin
                  pend_in = 1'b1;
                  rd_in = rd_ff + 1'b1;
               end else if (!pend_ff) begin
                  fill_in = wr_ff;
                  last_in = req_ff.now;
                  state_in = ST_APPEND;
               end
            end
         end
         ST_APPEND: begin
            if (fill_ff < CNT_BITS'(ENTRIES)) begin
               mem_we = 1'b1;
               mem_waddr = fill_ff[IDX_BITS-1:0];
               mem_wdata = {q_key, req_ff.handle, req_ff.etime};
               fill_in = fill_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_in = '0;
               state_in = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            if (pend_ff) begin
               if (paddr_ff == '0 || r_time < best_t_ff) begin
                  best_t_in = r_time;
                  best_idx_in = paddr_ff;
               end
            end
            if (rd_ff < CNT_BITS'(ENTRIES)) begin
               pend_in = 1'b1;
               paddr_in = rd_ff[IDX_BITS-1:0];
               rd_in = rd_ff + 1'b1;
            end else if (!pend_ff) begin
               mem_we = 1'b1;
               mem_waddr = best_idx_ff;
               mem_wdata = {q_key, req_ff.handle, req_ff.etime};
               state_in = ST_DONE;
            end
         end
         ST_FIND: begin
            if (pend_ff && r_key == q_key) begin
               rsp_in.hit = 1'b1;
               rsp_in.handle = r_handle;
               if (req_ff.op == OP_TOUCH) begin
                  mem_we = 1'b1;
                  mem_waddr = paddr_ff;
                  mem_wdata = {r_key, r_handle, req_ff.etime};
               end
               rsp_in.count = COUNT_BITS'(fill_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (rd_ff < fill_ff) begin
               pend_in = 1'b1;
               paddr_in = rd_ff[IDX_BITS-1:0];
               rd_in = rd_ff + 1'b1;
            end else if (!pend_ff) begin
               rsp_in = '{hit: 1'b0, handle: '0, count: COUNT_BITS'(fill_ff)};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            rsp_in = '{hit: 1'b0, handle: '0, count: COUNT_BITS'(fill_ff)};
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         interval_ff <= INTERVAL_RESET;
         max_age_ff <= MAX_AGE_RESET;
         fill_ff <= '0;
         last_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         interval_ff <= interval_in;
         max_age_ff <= max_age_in;
         fill_ff <= fill_in;
         last_ff <= last_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rd_ff <= rd_in;
      wr_ff <= wr_in;
      paddr_ff <= paddr_in;
      best_idx_ff <= best_idx_in;
      best_t_ff <= best_t_in;
      rsp_ff <= rsp_in;
   end

   // compaction never writes ahead of the read pointer
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AGE |-> wr_ff <= rd_ff)
      else $error("compaction overtook read");
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(ENTRIES))
      else $error("fill count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result shown while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VICTIM |-> fill_ff == CNT_BITS'(ENTRIES))
      else $error("victim search on non-full table");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_ff))
      else $error("result changed while stalled");
endmodule
